// ----- rtl/tlc_pkg.sv -----
// ----------------------------------------------------------------------------
// tlc_pkg
// Shared types and constants of the traffic light controller: phase codes,
// register indexes, reset durations and the lamp byte of each phase.
// ----------------------------------------------------------------------------
`default_nettype none

package tlc_pkg;

    localparam int unsigned DUR_W     = 16;
    localparam int unsigned SENSOR_W  = 3;
    localparam int unsigned LAMP_W    = 8;
    localparam int unsigned PHASE_W   = 3;
    localparam int unsigned CFG_IDX_W = 3;

    typedef enum logic [PHASE_W-1:0] {
        PH_GREEN   = 3'd0,
        PH_YELLOW  = 3'd1,
        PH_RED     = 3'd2,
        PH_EMERG   = 3'd3,
        PH_EXTEND  = 3'd4,
        PH_RECOVER = 3'd5
    } phase_t;

    localparam logic [CFG_IDX_W-1:0] REG_GREEN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_YELLOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RED     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EMERG   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EXTEND  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RECOVER = 3'd5;

    localparam logic [DUR_W-1:0] GREEN_RST   = 16'd500;
    localparam logic [DUR_W-1:0] YELLOW_RST  = 16'd150;
    localparam logic [DUR_W-1:0] RED_RST     = 16'd500;
    localparam logic [DUR_W-1:0] EMERG_RST   = 16'd500;
    localparam logic [DUR_W-1:0] EXTEND_RST  = 16'd750;
    localparam logic [DUR_W-1:0] RECOVER_RST = 16'd150;

    localparam logic [SENSOR_W-1:0] FLOW_ONE = 3'd3;

    localparam logic [LAMP_W-1:0] LAMP_GREEN  = 8'hDF;
    localparam logic [LAMP_W-1:0] LAMP_YELLOW = 8'hEF;
    localparam logic [LAMP_W-1:0] LAMP_RED    = 8'hF7;
    localparam logic [LAMP_W-1:0] LAMP_EMERG  = 8'h5F;
    localparam logic [LAMP_W-1:0] LAMP_EXTEND = 8'h9F;

    typedef struct packed {
        logic [DUR_W-1:0] green;
        logic [DUR_W-1:0] yellow;
        logic [DUR_W-1:0] red;
        logic [DUR_W-1:0] emerg;
        logic [DUR_W-1:0] extend;
        logic [DUR_W-1:0] recover;
    } durations_t;

    typedef struct packed {
        phase_t           phase;
        logic [DUR_W-1:0] count;
    } tlc_state_t;

    function automatic logic [LAMP_W-1:0] lamp_of(input phase_t ph);
        logic [LAMP_W-1:0] lamp;
        unique case (ph)
            PH_GREEN:   lamp = LAMP_GREEN;
            PH_YELLOW:  lamp = LAMP_YELLOW;
            PH_EMERG:   lamp = LAMP_EMERG;
            PH_EXTEND:  lamp = LAMP_EXTEND;
            PH_RECOVER: lamp = LAMP_YELLOW;
            default:    lamp = LAMP_RED;
        endcase
        return lamp;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/tlc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// tlc_cfg_regs
// Phase duration registers, written by index from the configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none

module tlc_cfg_regs (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              wr_en,
    input  wire logic [tlc_pkg::CFG_IDX_W-1:0]     wr_index,
    input  wire logic [tlc_pkg::DUR_W-1:0]         wr_data,
    output tlc_pkg::durations_t                    durations
);

    tlc_pkg::durations_t dur_reg;
    tlc_pkg::durations_t dur_next;

    always_comb begin
        dur_next = dur_reg;
        if (wr_en) begin
            unique case (wr_index)
                tlc_pkg::REG_GREEN:   dur_next.green   = wr_data;
                tlc_pkg::REG_YELLOW:  dur_next.yellow  = wr_data;
                tlc_pkg::REG_RED:     dur_next.red     = wr_data;
                tlc_pkg::REG_EMERG:   dur_next.emerg   = wr_data;
                tlc_pkg::REG_EXTEND:  dur_next.extend  = wr_data;
                tlc_pkg::REG_RECOVER: dur_next.recover = wr_data;
                default:              dur_next = dur_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dur_reg.green   <= tlc_pkg::GREEN_RST;
            dur_reg.yellow  <= tlc_pkg::YELLOW_RST;
            dur_reg.red     <= tlc_pkg::RED_RST;
            dur_reg.emerg   <= tlc_pkg::EMERG_RST;
            dur_reg.extend  <= tlc_pkg::EXTEND_RST;
            dur_reg.recover <= tlc_pkg::RECOVER_RST;
        end else begin
            dur_reg <= dur_next;
        end
    end

    assign durations = dur_reg;

endmodule

`default_nettype wire

// ----- rtl/tlc_phase_logic.sv -----
// ----------------------------------------------------------------------------
// tlc_phase_logic
// Next phase and tick count for one tick, from the current state, the sensor
// pattern, the emergency request and the phase durations.
// ----------------------------------------------------------------------------
`default_nettype none

module tlc_phase_logic (
    input  wire tlc_pkg::tlc_state_t             cur,
    input  wire logic [tlc_pkg::SENSOR_W-1:0]    sensors,
    input  wire logic                            emerg,
    input  wire tlc_pkg::durations_t             durations,
    output tlc_pkg::tlc_state_t                  nxt,
    output logic [tlc_pkg::LAMP_W-1:0]           lamp
);

    logic [tlc_pkg::DUR_W-1:0] dur;
    logic [tlc_pkg::DUR_W-1:0] cnt_inc;
    tlc_pkg::phase_t           seq_phase;

    always_comb begin
        unique case (cur.phase)
            tlc_pkg::PH_GREEN: begin
                dur       = durations.green;
                seq_phase = (sensors == tlc_pkg::FLOW_ONE) ? tlc_pkg::PH_EXTEND
                                                           : tlc_pkg::PH_YELLOW;
            end
            tlc_pkg::PH_YELLOW: begin
                dur       = durations.yellow;
                seq_phase = tlc_pkg::PH_RED;
            end
            tlc_pkg::PH_EMERG: begin
                dur       = durations.emerg;
                seq_phase = tlc_pkg::PH_RECOVER;
            end
            tlc_pkg::PH_EXTEND: begin
                dur       = durations.extend;
                seq_phase = tlc_pkg::PH_YELLOW;
            end
            tlc_pkg::PH_RECOVER: begin
                dur       = durations.recover;
                seq_phase = tlc_pkg::PH_RED;
            end
            default: begin
                dur       = durations.red;
                seq_phase = tlc_pkg::PH_GREEN;
            end
        endcase
    end

    assign cnt_inc = cur.count + 16'd1;

    always_comb begin
        nxt = cur;
        if (emerg && (cur.phase != tlc_pkg::PH_EMERG)) begin
            nxt.count = '0;
            if ((cur.phase == tlc_pkg::PH_GREEN) || (cur.phase == tlc_pkg::PH_YELLOW) ||
                (cur.phase == tlc_pkg::PH_RED)) begin
                nxt.phase = tlc_pkg::PH_EMERG;
            end
        end else if (cnt_inc >= dur) begin
            nxt.phase = seq_phase;
            nxt.count = '0;
        end else begin
            nxt.count = cnt_inc;
        end
    end

    assign lamp = tlc_pkg::lamp_of(nxt.phase);

endmodule

`default_nettype wire

// ----- rtl/traffic_light_controller_top.sv -----
// ----------------------------------------------------------------------------
// traffic_light_controller_top
// Traffic light phase controller: one input word per time tick, one lamp
// and phase word out per tick.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one word per tick, traffic sensor bits and emergency request.
//   m_ channel: one word per accepted tick, the active-low lamp byte and the
//   phase code after that tick, in input order.
//   cfg channel: cfg_index 0..5 selects green, yellow, red, emergency,
//   extension and recovery yellow durations in ticks; other indexes are
//   ignored. cfg_ready is always high. Write only while no tick is in flight.
// Path: an accepted s_ word passes through the input register, then the
//   phase/counter update into the output register, to become its m_ word.
// Throughput: one tick per cycle while m_tready does not stall the output; the
//   phase and 16-bit counter update is the only loop.
// Reset: phase red, counter zero, durations to their defaults, both stages
//   empty.
// Stall: with m_tready low the output word holds; the input register still
//   takes one more word, then s_tready drops until the output moves.
// ----------------------------------------------------------------------------
`default_nettype none

module traffic_light_controller_top (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [7:0]                          s_tdata,   // traffic_sensors[2:0], emergency[3]
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [15:0]                              m_tdata,   // lamp_pattern[7:0], light_phase[10:8]
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [tlc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [tlc_pkg::DUR_W-1:0]           cfg_data
);

    logic                               in_valid_reg;
    logic [tlc_pkg::SENSOR_W-1:0]       in_sensors_reg;
    logic                               in_emerg_reg;
    logic                               out_valid_reg;
    logic [tlc_pkg::LAMP_W-1:0]         out_lamp_reg;
    tlc_pkg::phase_t                    out_phase_reg;
    tlc_pkg::tlc_state_t                state_reg;
    tlc_pkg::tlc_state_t                state_next;
    logic [tlc_pkg::LAMP_W-1:0]         lamp_next;
    tlc_pkg::durations_t                durations;
    logic                               advance;
    logic                               s_accept;

    assign cfg_ready = 1'b1;

    tlc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (cfg_valid && cfg_ready),
        .wr_index  (cfg_index),
        .wr_data   (cfg_data),
        .durations (durations)
    );

    tlc_phase_logic u_logic (
        .cur       (state_reg),
        .sensors   (in_sensors_reg),
        .emerg     (in_emerg_reg),
        .durations (durations),
        .nxt       (state_next),
        .lamp      (lamp_next)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_sensors_reg <= s_tdata[tlc_pkg::SENSOR_W-1:0];
            in_emerg_reg   <= s_tdata[tlc_pkg::SENSOR_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase <= tlc_pkg::PH_RED;
            state_reg.count <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (advance) begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_lamp_reg  <= lamp_next;
            out_phase_reg <= state_next.phase;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_phase_reg, out_lamp_reg};

    a_emerg_forces: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_emerg_reg &&
        ((state_reg.phase == tlc_pkg::PH_GREEN) || (state_reg.phase == tlc_pkg::PH_YELLOW) ||
         (state_reg.phase == tlc_pkg::PH_RED))
        |=> (state_reg.phase == tlc_pkg::PH_EMERG) && (state_reg.count == '0))
        else $error("emergency did not force emergency phase");

    a_out_matches_state: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (out_phase_reg == state_reg.phase) && m_tvalid)
        else $error("output phase differs from state");

    a_change_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (state_next.phase != state_reg.phase) |=> state_reg.count == '0)
        else $error("phase change left counter nonzero");

    a_hold_state: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("state moved without a tick");

endmodule

`default_nettype wire
